// File: hdl/mexp_pkg.sv
// shared types and constants for the modular exponentiation unit
// no dependencies; imported by the controller, datapath and top level
package mexp_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int STEP_CNT_WIDTH = $clog2(OPERAND_WIDTH);

  typedef logic [OPERAND_WIDTH-1:0] operand_t;
  typedef logic [STEP_CNT_WIDTH-1:0] step_cnt_t;

  // which modular product the shared multiplier is working on
  typedef enum logic [1:0] {
    OP_REDUCE = 2'd0,  // base mod m, as (1 mod m) * base
    OP_MULT   = 2'd1,  // result * square
    OP_SQUARE = 2'd2   // square * square
  } mexp_op_t;

  // controller to datapath
  typedef struct packed {
    logic     load;
    logic     mul_start;
    logic     mul_step;
    logic     write;
    logic     out_load;
    mexp_op_t op;
  } mexp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic exp_zero;
    logic exp_lsb;
    logic mul_last;
  } mexp_sts_t;

  // (a + b) mod m with a < m and b < m
  function automatic operand_t add_reduced(operand_t a, operand_t b, operand_t m);
    operand_t gap;
    gap = m - b;
    return (a >= gap) ? (a - gap) : (a + b);
  endfunction

endpackage

// File: hdl/modular_exponentiation_unit.sv
// top level of the modular exponentiation unit (right-to-left square and multiply)
// depends on mexp_pkg, mexp_ctrl and mexp_dpath
//
//   channel | handshake            | words carried
//   --------+----------------------+----------------------------------------
//   in      | in_valid / in_stall  | in_base_value, in_exponent_value
//   out     | out_valid / out_stall| out_power_result
//   cfg     | cfg_valid / cfg_ready| cfg_modulus (zero is ignored)
//
// one word at a time; each modular product runs on the shared bit-serial
// multiplier as start, one step per operand bit, write back, decide; a word needs
// 1 + k + p products, k = exponent bit length, p = its set bits, and a zero
// exponent skips the multiplier. synchronous active-low reset, modulus
// resets to 1. in_stall is high from the accept until the result sits in the
// output register, which may still hold while the next word comes in.
module modular_exponentiation_unit import mexp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  operand_t cfg_modulus,
  input  logic     in_valid,
  output logic     in_stall,
  input  operand_t in_base_value,
  input  operand_t in_exponent_value,
  output logic     out_valid,
  input  logic     out_stall,
  output operand_t out_power_result
);

  mexp_cmd_t cmd;
  mexp_sts_t sts;

  assign cfg_ready = 1'b1;

  // sequencer
  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // registers and multiplier
  mexp_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_modulus       (cfg_modulus),
    .in_base_value     (in_base_value),
    .in_exponent_value (in_exponent_value),
    .out_power_result  (out_power_result),
    .cmd               (cmd),
    .sts               (sts)
  );

`ifndef SYNTHESIS
  // an accepted word keeps the unit busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("unit not busy after accepting a word");

  // loading the output register always presents a result
  a_out_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("result loaded but out_valid low");

  // a multiplier start is always followed by a step
  a_step_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_start |=> cmd.mul_step)
    else $error("multiplier started but not stepped");

  // no new word is taken while the multiplier runs
  a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mul_step || cmd.write) |-> !cmd.load)
    else $error("word loaded during a multiplication");
`endif

endmodule

// File: hdl/mexp_ctrl.sv
// controller for the modular exponentiation unit: sequences the shared multiplier
// over the exponent bits and handles both handshakes; depends on mexp_pkg
module mexp_ctrl import mexp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  mexp_sts_t sts,
  output mexp_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_PREP  = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_WB    = 7'b0010000,
    S_NEXT  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t   state_r, state_nxt;
  mexp_op_t op_r, op_nxt;
  logic     out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cmd           = '0;
    cmd.op        = op_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.exp_zero) begin
          state_nxt = S_DONE;
        end else begin
          op_nxt    = OP_REDUCE;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_last) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        cmd.write = 1'b1;
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        // after a multiply comes the square; otherwise pick by the next exponent bit
        if (op_r == OP_MULT) begin
          op_nxt    = OP_SQUARE;
          state_nxt = S_PREP;
        end else if (sts.exp_zero) begin
          state_nxt = S_DONE;
        end else begin
          op_nxt    = sts.exp_lsb ? OP_MULT : OP_SQUARE;
          state_nxt = S_PREP;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_REDUCE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hdl/mexp_dpath.sv
// datapath for the modular exponentiation unit: modulus register, operand registers
// and a bit-serial interleaved modular multiplier; depends on mexp_pkg
module mexp_dpath import mexp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_valid,
  input  operand_t  cfg_modulus,
  input  operand_t  in_base_value,
  input  operand_t  in_exponent_value,
  output operand_t  out_power_result,
  input  mexp_cmd_t cmd,
  output mexp_sts_t sts
);

  operand_t  mod_r;
  operand_t  base_r;
  operand_t  exp_r;
  operand_t  res_r;
  operand_t  sq_r;
  operand_t  acc_r;
  operand_t  mul_a_r;
  operand_t  mul_b_r;
  step_cnt_t cnt_r;
  operand_t  pow_r;

  operand_t one_mod;
  operand_t acc_dbl;
  operand_t acc_nxt;
  operand_t sel_a;
  operand_t sel_b;

  // 1 mod m
  assign one_mod = (mod_r == operand_t'(1)) ? '0 : operand_t'(1);

  // one multiplier step: double, then add a when the current b bit is set
  assign acc_dbl = add_reduced(acc_r, acc_r, mod_r);
  assign acc_nxt = mul_b_r[OPERAND_WIDTH-1] ? add_reduced(acc_dbl, mul_a_r, mod_r) : acc_dbl;

  // operand select
  always_comb begin
    case (cmd.op)
      OP_REDUCE: begin
        sel_a = one_mod;
        sel_b = base_r;
      end
      OP_MULT: begin
        sel_a = res_r;
        sel_b = sq_r;
      end
      default: begin
        sel_a = sq_r;
        sel_b = sq_r;
      end
    endcase
  end

  // modulus register, zero writes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= operand_t'(1);
    end else if (cfg_valid && (cfg_modulus != '0)) begin
      mod_r <= cfg_modulus;
    end
  end

  // operand and multiplier registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r <= in_base_value;
      exp_r  <= in_exponent_value;
      res_r  <= (in_exponent_value == '0) ? operand_t'(1) : one_mod;
    end
    if (cmd.mul_start) begin
      acc_r   <= '0;
      mul_a_r <= sel_a;
      mul_b_r <= sel_b;
      cnt_r   <= '0;
    end
    if (cmd.mul_step) begin
      acc_r   <= acc_nxt;
      mul_b_r <= mul_b_r << 1;
      cnt_r   <= cnt_r + step_cnt_t'(1);
    end
    if (cmd.write) begin
      case (cmd.op)
        OP_MULT: begin
          res_r <= acc_r;
        end
        OP_SQUARE: begin
          sq_r  <= acc_r;
          exp_r <= exp_r >> 1;
        end
        default: begin
          sq_r <= acc_r;
        end
      endcase
    end
    if (cmd.out_load) begin
      pow_r <= res_r;
    end
  end

  assign out_power_result = pow_r;

  assign sts.exp_zero = (exp_r == '0);
  assign sts.exp_lsb  = exp_r[0];
  assign sts.mul_last = (cnt_r == step_cnt_t'(OPERAND_WIDTH - 1));

endmodule

// File: bench/modular_exponentiation_unit_tb.sv
// testbench for modular_exponentiation_unit: random and directed words against a
// square-and-multiply predictor, over several modulus settings; needs mexp_pkg and the rtl
`timescale 1ns / 1ps

module modular_exponentiation_unit_tb;
  import mexp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    operand_t base;
    operand_t exponent;
  } power_word_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  operand_t cfg_modulus = '0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  operand_t in_base_value = '0;
  operand_t in_exponent_value = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  operand_t out_power_result;

  power_word_t word_queue[$];
  operand_t    pending_powers[$];
  operand_t    modulus_shadow = 32'd1;
  power_word_t next_word;
  operand_t    expected_power;
  int          words_queued = 0;
  int          words_accepted = 0;
  int          results_checked = 0;
  int          mismatch_count = 0;
  int          settings_seen = 1;
  int          burst_left = 1;
  int          gap_left = 0;
  int          idle_cycles = 0;
  logic [5:0]  stall_step = '0;
  logic [15:0] stall_pattern = '0;

  modular_exponentiation_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_modulus      (cfg_modulus),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_base_value    (in_base_value),
    .in_exponent_value(in_exponent_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_power_result (out_power_result)
  );

  always #10 clk = ~clk;

  // base ** exponent mod modulus, right to left, products kept at 64 bits
  function automatic operand_t mod_power(operand_t base, operand_t exponent,
                                         operand_t modulus);
    logic [63:0] result;
    logic [63:0] square;
    operand_t    bits_left;
    if (exponent == '0) return operand_t'(1);
    result = 64'(1) % 64'(modulus);
    square = 64'(base) % 64'(modulus);
    bits_left = exponent;
    while (bits_left != '0) begin
      if (bits_left[0]) result = (result * square) % 64'(modulus);
      square = (square * square) % 64'(modulus);
      bits_left = bits_left >> 1;
    end
    return operand_t'(result);
  endfunction

  task automatic queue_word(input operand_t base, input operand_t exponent);
    word_queue.push_back('{base, exponent});
    words_queued++;
  endtask

  // register write, only issued while the unit is idle
  task automatic write_modulus(input operand_t value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_modulus <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (value != '0) modulus_shadow = value;
    settings_seen++;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (results_checked != words_queued);
  endtask

  // random words, biased toward extremes and bases near the modulus
  task automatic queue_random_words(input int count);
    operand_t base;
    operand_t exponent;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: base = operand_t'($urandom);
        3:       base = modulus_shadow - 1;
        4:       base = modulus_shadow;
        5:       base = modulus_shadow + operand_t'($urandom_range(1, 3));
        6:       base = operand_t'($urandom_range(0, 3));
        7:       base = '1 - operand_t'($urandom_range(0, 3));
        default: base = operand_t'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: exponent = operand_t'($urandom);
        4, 5:       exponent = operand_t'($urandom_range(0, 255));
        6:          exponent = '0;
        7:          exponent = operand_t'(1) << $urandom_range(0, 31);
        8:          exponent = operand_t'('1) >> $urandom_range(0, 31);
        default:    exponent = operand_t'($urandom_range(1, 15));
      endcase
      queue_word(base, exponent);
    end
  endtask

  // word driver: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_powers.push_back(mod_power(in_base_value, in_exponent_value, modulus_shadow));
        words_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 || word_queue.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          next_word = word_queue.pop_front();
          in_valid <= 1'b1;
          in_base_value <= next_word.base;
          in_exponent_value <= next_word.exponent;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 8);
            if ($urandom_range(0, 3) == 0) gap_left = 0;
            else if ($urandom_range(0, 7) == 0) gap_left = $urandom_range(100, 2500);
            else gap_left = $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // result stall: a 16-bit mask, redrawn each time the 6-bit step counter wraps, sometimes all clear
  always @(posedge clk) begin
    stall_step <= stall_step + 1'b1;
    if (stall_step == '1) begin
      stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
    end
    out_stall <= stall_pattern[stall_step[3:0]];
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_powers.size() == 0) begin
        $error("power_result: no word outstanding, got %h", out_power_result);
        mismatch_count++;
      end else begin
        expected_power = pending_powers.pop_front();
        results_checked++;
        if (out_power_result !== expected_power) begin
          $error("power_result: expected %h, actual %h", expected_power, out_power_result);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles where no channel moves a word
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    operand_t phase_modulus;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // modulus still at its reset value of one
    queue_word(32'd5, 32'd0);
    queue_word(32'd0, 32'd0);
    queue_word(32'd7, 32'd3);
    queue_word('1, '1);
    wait_drained();

    // zero write must leave the modulus at one
    write_modulus('0);
    queue_word(32'd7, 32'd3);
    queue_word(32'd9, 32'd0);
    wait_drained();

    // largest modulus: base equal to it, full-width exponents, large products
    write_modulus('1);
    queue_word(32'd0, 32'd1);
    queue_word('1, 32'd1);
    queue_word(32'hFFFF_FFFE, '1);
    queue_word(32'd2, 32'd31);
    queue_word(32'd2, 32'd32);
    queue_word(32'hFFFF_FFFE, 32'd2);
    queue_word(32'd3, 32'h8000_0000);
    queue_word(32'd0, 32'd0);
    queue_word(32'd1, '1);
    queue_word(32'd12345, 32'd65537);
    wait_drained();

    write_modulus(32'd2);
    queue_word(32'd3, 32'd5);
    queue_word(32'd4, '1);
    wait_drained();

    // prime just below the top, base above it
    write_modulus(32'hFFFF_FFFB);
    queue_word('1, 32'd3);
    queue_word(32'hFFFF_FFFA, '1);
    wait_drained();

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0:       phase_modulus = operand_t'($urandom);
        1:       phase_modulus = '1;
        2:       phase_modulus = operand_t'($urandom_range(2, 255));
        3:       phase_modulus = 32'hFFFF_FFFB;
        4:       phase_modulus = 32'h8000_0000 | operand_t'($urandom);
        5:       phase_modulus = operand_t'($urandom_range(256, 65535));
        default: phase_modulus = 32'd1;
      endcase
      write_modulus(phase_modulus);
      queue_random_words((phase == 6) ? 20 : 42);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_powers.size() != 0) begin
      $error("power_result: %0d results never arrived", pending_powers.size());
      mismatch_count += pending_powers.size();
    end
    $display("%0d words checked over %0d modulus writes, including zero exponents,",
             results_checked, settings_seen - 1);
    $display("bases at and above the modulus, and moduli of one, two and the full range");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
